// ===== hw/rtl/hcbd_pkg.sv =====
package hcbd_pkg;

  // width of the chunk size counter
  localparam int unsigned SizeBits = 32;
  localparam int unsigned PhaseW   = 4;

  typedef logic [SizeBits-1:0] size_t;
  typedef logic [PhaseW-1:0]   phase_t;

  // decoder phases
  localparam phase_t PhFirst       = 4'd0;
  localparam phase_t PhDigits      = 4'd1;
  localparam phase_t PhDigitsCr    = 4'd2;
  localparam phase_t PhExt         = 4'd3;
  localparam phase_t PhExtCr       = 4'd4;
  localparam phase_t PhData        = 4'd5;
  localparam phase_t PhDataCr      = 4'd6;
  localparam phase_t PhDataLf      = 4'd7;
  localparam phase_t PhTrlStart    = 4'd8;
  localparam phase_t PhTrlStartCr  = 4'd9;
  localparam phase_t PhTrlMid      = 4'd10;
  localparam phase_t PhTrlMidCr    = 4'd11;
  localparam phase_t PhComplete    = 4'd12;
  localparam phase_t PhInvalid     = 4'd13;

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSemi = 8'h3B;

  typedef enum logic [1:0] {
    StatusIncomplete = 2'd0,
    StatusComplete   = 2'd1,
    StatusInvalid    = 2'd2
  } status_e;

  // one byte held in the input stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t r;
    r.is_hex = 1'b1;
    r.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else begin
      r.is_hex = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hcbd_stream_if.sv =====
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       payload_valid;
  logic [1:0] status;

  modport source (output valid, output out_byte, output payload_valid, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input payload_valid, input status,
                  output ready);
endinterface

// ===== hw/rtl/hcbd_in_stage.sv =====
module hcbd_in_stage
  import hcbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  output beat_t      beat_o,
  input  logic       take_i
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  // stage is free when empty or when its byte moves on this cycle
  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= byte_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.data  = data_q;

endmodule

// ===== hw/rtl/hcbd_core.sv =====
module hcbd_core
  import hcbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  beat_t      beat_i,
  output logic       take_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic       payload_valid_o,
  output status_e    status_o
);

  phase_t     phase_q, phase_d;
  size_t      size_q, size_d;
  size_t      left_q, left_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       pv_q, pv_d;
  status_e    status_q, status_d;
  hex_t       hx;
  logic [7:0] c;
  logic       ovf;
  size_t      size_push;

  assign c         = beat_i.data;
  assign hx        = hex_decode(c);
  assign ovf       = size_q[SizeBits-1 -: 4] != 4'd0;
  assign size_push = {size_q[SizeBits-5:0], hx.value};

  // result register is free when empty or being drained
  assign take_o = beat_i.valid && (!out_valid_q || ready_i);

  always_comb begin
    phase_d    = phase_q;
    size_d     = size_q;
    left_d     = left_q;
    out_byte_d = 8'd0;
    pv_d       = 1'b0;
    unique case (phase_q)
      PhFirst: begin
        if (hx.is_hex) begin
          size_d  = {{(SizeBits-4){1'b0}}, hx.value};
          phase_d = PhDigits;
        end else begin
          phase_d = PhInvalid;
        end
      end
      PhDigits: begin
        if (hx.is_hex) begin
          if (ovf) phase_d = PhInvalid;
          else     size_d  = size_push;
        end else if (c == ChSemi) begin
          phase_d = PhExt;
        end else if (c == ChCr) begin
          phase_d = PhDigitsCr;
        end else begin
          phase_d = PhInvalid;
        end
      end
      PhDigitsCr, PhExtCr: begin
        if (c == ChLf) begin
          // end of size line
          if (size_q == '0) begin
            phase_d = PhTrlStart;
          end else begin
            left_d  = size_q;
            phase_d = PhData;
          end
          size_d = '0;
        end else if (phase_q == PhDigitsCr) begin
          phase_d = PhInvalid;
        end else if (c != ChCr) begin
          phase_d = PhExt;
        end
      end
      PhExt: begin
        if (c == ChCr) phase_d = PhExtCr;
      end
      PhData: begin
        out_byte_d = c;
        pv_d       = 1'b1;
        if (left_q != '0) left_d = left_q - 1'b1;
        if (left_q <= size_t'(1)) phase_d = PhDataCr;
      end
      PhDataCr: phase_d = (c == ChCr) ? PhDataLf : PhInvalid;
      PhDataLf: phase_d = (c == ChLf) ? PhFirst : PhInvalid;
      PhTrlStart: phase_d = (c == ChCr) ? PhTrlStartCr : PhTrlMid;
      PhTrlStartCr: begin
        if (c == ChLf)      phase_d = PhComplete;
        else if (c == ChCr) phase_d = PhTrlMidCr;
        else                phase_d = PhTrlMid;
      end
      PhTrlMid: begin
        if (c == ChCr) phase_d = PhTrlMidCr;
      end
      PhTrlMidCr: begin
        if (c == ChLf)      phase_d = PhTrlStart;
        else if (c != ChCr) phase_d = PhTrlMid;
      end
      PhComplete: phase_d = PhComplete;
      default:    phase_d = PhInvalid;
    endcase
  end

  always_comb begin
    if (phase_d == PhComplete)     status_d = StatusComplete;
    else if (phase_d == PhInvalid) status_d = StatusInvalid;
    else                           status_d = StatusIncomplete;
  end

  assign out_valid_d = take_o ? 1'b1 : (ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhFirst;
      size_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        phase_q <= phase_d;
        size_q  <= size_d;
        left_q  <= left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_byte_q <= out_byte_d;
      pv_q       <= pv_d;
      status_q   <= status_d;
    end
  end

  assign valid_o         = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign payload_valid_o = pv_q;
  assign status_o        = status_q;

endmodule

// ===== hw/rtl/http_chunked_body_decoder.sv =====
// chunked http body decoder
// in_i carries the raw chunked body, one byte per transaction. out_o gives
// one result transaction per input byte, in order: out_byte with
// payload_valid set when the byte was chunk data (out_byte is zero
// otherwise), and status: incomplete, complete after the final empty line,
// or invalid framing. complete and invalid are sticky until reset.
// a byte accepted on in_i is registered in the input stage, then decoded into
// the result register once that register is free, and shows on out_o from
// then on. throughput: one byte per cycle while out_o is not stalled; the
// phase, size and remaining-count registers update once per accepted byte.
// reset: the decoder expects the first size digit and both stages are empty.
// when the receiver stalls, the result holds and the input register takes
// one more byte; after that in_i.ready drops until out_o drains.
module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);

  beat_t   beat;
  logic    take;
  status_e status;

  hcbd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .byte_i  (in_i.in_byte),
    .ready_o (in_i.ready),
    .beat_o  (beat),
    .take_i  (take)
  );

  hcbd_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beat_i          (beat),
    .take_o          (take),
    .valid_o         (out_o.valid),
    .ready_i         (out_o.ready),
    .out_byte_o      (out_o.out_byte),
    .payload_valid_o (out_o.payload_valid),
    .status_o        (status)
  );

  assign out_o.status = status;

endmodule

// ===== hw/rtl/hcbd_checker.sv =====
module hcbd_checker
  import hcbd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       payload_valid_i,
  input logic [1:0] status_i
);

  logic out_fire;
  logic done_q;
  logic [1:0] final_q;

  assign out_fire = out_valid_i && out_ready_i;

  // remember the first final status delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      final_q <= StatusIncomplete;
    end else if (out_fire && !done_q && status_i != StatusIncomplete) begin
      done_q  <= 1'b1;
      final_q <= status_i;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_byte_i) && $stable(payload_valid_i) && $stable(status_i))
    else $error("result changed while stalled");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && done_q |-> status_i == final_q && !payload_valid_i)
    else $error("final status not sticky");

  a_payload_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && payload_valid_i |-> status_i == StatusIncomplete)
    else $error("payload byte with final status");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_byte_i      (out_o.out_byte),
  .payload_valid_i (out_o.payload_valid),
  .status_i        (out_o.status)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import hcbd_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_valid;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       typed;
    result_t    res;
  } dir_row_t;

  typedef enum int {
    EndComplete,
    EndEmptySize,
    EndBadDigit,
    EndDigitsNoLf,
    EndOverflow,
    EndDataNoCr,
    EndDataNoLf
  } finish_e;

  localparam int DirLen   = 20;
  localparam int RandBytes = 930;
  localparam int TailBytes = 12;

  logic clk_i;
  logic rst_ni;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();

  http_chunked_body_decoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // directed body: one chunk of two bytes with an extension holding a lone cr,
  // then a one-byte chunk with leading zeros whose payload is a cr
  dir_row_t dir_rows [DirLen] = '{
    '{"0",   1'b1, '{8'h00, 1'b0, StatusIncomplete}},
    '{"2",   1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChSemi, 1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{"x",   1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChCr,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{"y",   1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChCr,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChLf,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{8'hFF, 1'b1, '{8'hFF, 1'b1, StatusIncomplete}},
    '{8'h00, 1'b1, '{8'h00, 1'b1, StatusIncomplete}},
    '{ChCr,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChLf,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{"0",   1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{"0",   1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{"1",   1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChCr,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChLf,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChCr,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChCr,  1'b0, '{8'h00, 1'b0, StatusIncomplete}},
    '{ChLf,  1'b0, '{8'h00, 1'b0, StatusIncomplete}}
  };

  // decoder copy kept by the bench
  phase_t  dec_phase = PhFirst;
  size_t   dec_size  = '0;
  size_t   dec_left  = '0;

  result_t pending_results [$];
  int      n_bytes   = 0;
  int      n_payload = 0;
  int      n_chunks  = 0;
  int      longest   = 0;
  int      errors    = 0;
  bit      calm      = 1'b0;
  bit      hold_req  = 1'b0;
  finish_e finish_kind;

  function automatic bit is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    if (c <= "9") begin
      return 4'(c - "0");
    end
    return 4'((c | 8'h20) - "a" + 10);
  endfunction

  function automatic bit shift_digit(logic [3:0] d);
    if (dec_size[SizeBits-1 -: 4] != 4'd0) begin
      return 1'b0;
    end
    dec_size = {dec_size[SizeBits-5:0], d};
    return 1'b1;
  endfunction

  function automatic void close_size_line();
    if (dec_size == '0) begin
      dec_phase = PhTrlStart;
    end else begin
      dec_left  = dec_size;
      dec_phase = PhData;
    end
    dec_size = '0;
  endfunction

  function automatic result_t decode_byte(logic [7:0] c);
    result_t r;
    r = '{8'h00, 1'b0, StatusIncomplete};
    case (dec_phase)
      PhFirst: begin
        dec_size = '0;
        if (!is_hex(c)) begin
          dec_phase = PhInvalid;
        end else begin
          dec_phase = shift_digit(hex_val(c)) ? PhDigits : PhInvalid;
        end
      end
      PhDigits: begin
        if (is_hex(c)) begin
          if (!shift_digit(hex_val(c))) dec_phase = PhInvalid;
        end else if (c == ChSemi) begin
          dec_phase = PhExt;
        end else if (c == ChCr) begin
          dec_phase = PhDigitsCr;
        end else begin
          dec_phase = PhInvalid;
        end
      end
      PhDigitsCr: begin
        if (c == ChLf) close_size_line();
        else dec_phase = PhInvalid;
      end
      PhExt: begin
        if (c == ChCr) dec_phase = PhExtCr;
      end
      PhExtCr: begin
        if (c == ChLf) close_size_line();
        else if (c != ChCr) dec_phase = PhExt;
      end
      PhData: begin
        r.out_byte      = c;
        r.payload_valid = 1'b1;
        if (dec_left != '0) dec_left--;
        if (dec_left == '0) dec_phase = PhDataCr;
      end
      PhDataCr:   dec_phase = (c == ChCr) ? PhDataLf : PhInvalid;
      PhDataLf:   dec_phase = (c == ChLf) ? PhFirst : PhInvalid;
      PhTrlStart: dec_phase = (c == ChCr) ? PhTrlStartCr : PhTrlMid;
      PhTrlStartCr: begin
        if (c == ChLf) dec_phase = PhComplete;
        else if (c == ChCr) dec_phase = PhTrlMidCr;
        else dec_phase = PhTrlMid;
      end
      PhTrlMid: begin
        if (c == ChCr) dec_phase = PhTrlMidCr;
      end
      PhTrlMidCr: begin
        if (c == ChLf) dec_phase = PhTrlStart;
        else if (c != ChCr) dec_phase = PhTrlMid;
      end
      PhComplete: ;
      default: dec_phase = PhInvalid;
    endcase
    if (dec_phase == PhComplete) r.status = StatusComplete;
    else if (dec_phase == PhInvalid) r.status = StatusInvalid;
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return 8'(8'h30 + d);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10);
  endfunction

  // a byte that cannot start or continue the hex size
  function automatic logic [7:0] pick_nonhex(bit semi_cr_ok);
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = 8'h00;
      1: c = " ";
      2: c = "x";
      3: c = ChSemi;
      4: c = ChCr;
      5: c = "-";
      default: c = 8'($urandom_range(0, 255));
    endcase
    while (is_hex(c) || (!semi_cr_ok && (c == ChSemi || c == ChCr))) begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_other(logic [7:0] avoid);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == avoid) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  function automatic void flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
    errors++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  task automatic send_byte(logic [7:0] b, bit typed = 1'b0, result_t typed_res = '0);
    int gap;
    result_t want;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    want = decode_byte(b);
    if (typed) want = typed_res;
    if (want.payload_valid) n_payload++;
    pending_results.push_back(want);
    n_bytes++;
  endtask

  // random text with no cr lf pair in it
  task automatic send_free_text(int len);
    logic [7:0] c;
    logic [7:0] prev;
    prev = 8'h00;
    repeat (len) begin
      c = 8'($urandom_range(0, 255));
      if (prev == ChCr && c == ChLf) c = "x";
      send_byte(c);
      prev = c;
    end
  endtask

  task automatic send_size_line(int unsigned size);
    int n;
    int i;
    n = 1;
    while (n < 8 && (size >> (4 * n)) != 0) n++;
    if ($urandom_range(0, 9) >= 7) begin
      repeat ($urandom_range(1, 10)) send_byte("0");
    end
    for (i = n - 1; i >= 0; i--) send_byte(hex_char(4'(size >> (4 * i))));
    if ($urandom_range(0, 3) == 0) begin
      send_byte(ChSemi);
      send_free_text($urandom_range(0, 6));
    end
    send_byte(ChCr);
    send_byte(ChLf);
  endtask

  task automatic send_data(int unsigned size);
    repeat (size) send_byte(8'($urandom_range(0, 255)));
    n_chunks++;
    if (size > longest) longest = size;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int stall;
    result_t want;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 20) $error("result with no pending byte: out_byte %0h", out_if.out_byte);
        end else begin
          want = pending_results.pop_front();
          if (out_if.out_byte !== want.out_byte) begin
            flag_mismatch("out_byte", want.out_byte, out_if.out_byte);
          end
          if (out_if.payload_valid !== want.payload_valid) begin
            flag_mismatch("payload_valid", want.payload_valid, out_if.payload_valid);
          end
          if (out_if.status !== want.status) begin
            flag_mismatch("status", want.status, out_if.status);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 64;
      end
      if (stall == 0) stall = pick_gap();
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : byte_source
    bit held;
    bit paused;
    int unsigned sz;
    int i;
    held   = 1'b0;
    paused = 1'b0;
    rst_ni = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) send_byte(dir_rows[k].in_byte, dir_rows[k].typed, dir_rows[k].res);

    while (n_bytes < RandBytes) begin
      calm = (n_chunks % 10) == 4;
      if (!held && n_bytes > 300) begin
        // receiver stops for a while, input must back up
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && n_bytes > 600) begin
        paused = 1'b1;
        drain();
      end
      sz = pick_size();
      send_size_line(sz);
      send_data(sz);
      send_byte(ChCr);
      send_byte(ChLf);
    end
    calm = 1'b0;

    // the body can end only once per run, so the seed picks how
    finish_kind = finish_e'($urandom_range(0, 6));
    case (finish_kind)
      EndComplete: begin
        send_size_line(0);
        repeat ($urandom_range(0, 3)) begin
          send_free_text($urandom_range(1, 6));
          send_byte(ChCr);
          send_byte(ChLf);
        end
        send_byte(ChCr);
        send_byte(ChLf);
      end
      EndEmptySize: send_byte(pick_nonhex(1'b1));
      EndBadDigit: begin
        repeat ($urandom_range(1, 3)) send_byte(hex_char(4'($urandom_range(0, 15))));
        send_byte(pick_nonhex(1'b0));
      end
      EndDigitsNoLf: begin
        send_byte(hex_char(4'($urandom_range(1, 15))));
        send_byte(ChCr);
        send_byte(pick_other(ChLf));
      end
      EndOverflow: begin
        // nine significant digits no longer fit the size counter
        repeat ($urandom_range(0, 4)) send_byte("0");
        send_byte(hex_char(4'($urandom_range(1, 15))));
        for (i = 0; i < 8; i++) send_byte(hex_char(4'($urandom_range(0, 15))));
      end
      EndDataNoCr: begin
        sz = $urandom_range(1, 8);
        send_size_line(sz);
        send_data(sz);
        send_byte(pick_other(ChCr));
      end
      default: begin
        sz = $urandom_range(1, 8);
        send_size_line(sz);
        send_data(sz);
        send_byte(ChCr);
        send_byte(pick_other(ChLf));
      end
    endcase

    // status must stick from here on
    repeat (TailBytes) send_byte(8'($urandom_range(0, 255)));
    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d bytes over %0d chunks, %0d payload bytes, longest chunk %0d",
             n_bytes, n_chunks, n_payload, longest);
    $display("body ended by %s, then %0d bytes checked for sticky status",
             finish_kind.name(), TailBytes);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
